// ===== rtl/core/qes_pkg.sv =====
// Shared types, codes and helpers of the quadratic equation solver.
// Depends on nothing; every module but qes_delay imports it.
`timescale 1ns / 1ps

package qes_pkg;

    // Field widths and internal datapath widths.
    localparam int IN_W      = 16;
    localparam int OUT_W     = 32;
    localparam int SQ_IN_W   = 34;
    localparam int SQ_ROOT_W = 34;
    localparam int SQ_REM_W  = 36;
    localparam int SQ_STEPS  = 33;
    localparam int SQ_FRAC   = 16;
    localparam int DIV_N     = 40;
    localparam int DIV_M     = 17;
    localparam int NB_W      = 33;
    localparam int EXT_W     = 40;

    // Root kind codes.
    localparam logic [1:0] RK_NONE    = 2'd0;
    localparam logic [1:0] RK_TWO     = 2'd1;
    localparam logic [1:0] RK_DOUBLE  = 2'd2;
    localparam logic [1:0] RK_COMPLEX = 2'd3;

    // Extremum kind codes.
    localparam logic [1:0] EK_NONE = 2'd0;
    localparam logic [1:0] EK_MIN  = 2'd1;
    localparam logic [1:0] EK_MAX  = 2'd2;

    typedef struct packed {
        logic signed [IN_W-1:0] coef_a;
        logic signed [IN_W-1:0] coef_b;
        logic signed [IN_W-1:0] coef_c;
        logic signed [IN_W-1:0] point_x;
    } coef_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value_at_point;
        logic [1:0]              root_kind;
        logic signed [OUT_W-1:0] root_first;
        logic signed [OUT_W-1:0] root_second;
        logic [1:0]              extreme_kind;
        logic signed [OUT_W-1:0] extreme_value;
        logic                    saturated;
    } result_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] v;
        logic                    sat;
    } clip_t;

    // Clip a wide signed value to the output range and flag the clip.
    function automatic clip_t clip_out(input logic signed [63:0] v);
        clip_t r;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        r.sat = 1'b0;
        if (v > hi) begin
            r.v   = hi[OUT_W-1:0];
            r.sat = 1'b1;
        end else if (v < lo) begin
            r.v   = lo[OUT_W-1:0];
            r.sat = 1'b1;
        end else begin
            r.v = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/qes_delay.sv =====
// Delay line that carries a valid bit and a side word alongside a pipelined unit.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module qes_delay #(
    parameter int W = 8,
    parameter int L = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic         valid_reg [L];
    logic [W-1:0] data_reg  [L];

    // Valid bits are control state and clear on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < L; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < L; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Side words move one tap per enabled cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= in_data;
            for (int k = 1; k < L; k++)
            begin
                data_reg[k] <= data_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[L-1];
    assign out_data  = data_reg[L-1];

endmodule

// ===== rtl/core/qes_front.sv =====
// Front end: products, polynomial value, discriminant and extremum numerator.
// Depends on qes_pkg. Three register stages.
`timescale 1ns / 1ps

module qes_front
    import qes_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  coef_t                   coef,
    output logic                    out_valid,
    output logic signed [OUT_W-1:0] val,
    output logic                    val_sat,
    output logic [1:0]              kind,
    output logic [SQ_IN_W-1:0]      d_mag,
    output logic signed [NB_W-1:0]  nb,
    output logic signed [IN_W-1:0]  a,
    output logic signed [EXT_W-1:0] ext_num
);

    logic v1_reg, v2_reg, v3_reg;

    // Stage 1 registers: first products.
    logic signed [31:0]     s1_xx_reg, s1_bx_reg, s1_bb_reg, s1_ac_reg;
    logic signed [IN_W-1:0] s1_a_reg, s1_b_reg, s1_c_reg;

    // Stage 2 registers.
    logic signed [47:0]      s2_axx_reg;
    logic signed [31:0]      s2_bx_reg;
    logic signed [IN_W-1:0]  s2_c_reg, s2_a_reg, s2_b_reg;
    logic signed [33:0]      s2_d_reg;
    logic signed [EXT_W-1:0] s2_ext_reg;

    // Stage 3 registers.
    logic signed [OUT_W-1:0] s3_val_reg;
    logic                    s3_sat_reg;
    logic [1:0]              s3_kind_reg;
    logic [SQ_IN_W-1:0]      s3_dmag_reg;
    logic signed [NB_W-1:0]  s3_nb_reg;
    logic signed [IN_W-1:0]  s3_a_reg;
    logic signed [EXT_W-1:0] s3_ext_reg;

    logic signed [IN_W-1:0]  ca, cb, cc, cx;
    logic signed [33:0]      bb34, ac34, d_next;
    logic signed [EXT_W-1:0] ac40, bb40, ext_next;
    logic signed [49:0]      num, quot;
    clip_t                   vclip;
    logic [1:0]              kind_next;
    logic signed [NB_W-1:0]  b33;

    assign ca = coef.coef_a;
    assign cb = coef.coef_b;
    assign cc = coef.coef_c;
    assign cx = coef.point_x;

    // Valid bits follow the data through the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Discriminant and extremum numerator from the stage 1 products.
    always_comb
    begin
        bb34     = 34'(s1_bb_reg);
        ac34     = 34'(s1_ac_reg);
        d_next   = bb34 - (ac34 <<< 2);
        ac40     = 40'(s1_ac_reg);
        bb40     = 40'(s1_bb_reg);
        ext_next = (ac40 <<< 8) - (bb40 <<< 6);
    end

    // Polynomial value, truncated toward zero, and the root kind.
    always_comb
    begin
        num = 50'(s2_axx_reg) + (50'(s2_bx_reg) <<< 8) + (50'(s2_c_reg) <<< 16);
        if (num < 0)
        begin
            quot = (num + 50'sd255) >>> 8;
        end else
        begin
            quot = num >>> 8;
        end
        vclip = clip_out(64'(quot));
        if (s2_a_reg == '0)
        begin
            kind_next = RK_NONE;
        end else if (s2_d_reg > 0)
        begin
            kind_next = RK_TWO;
        end else if (s2_d_reg == 0)
        begin
            kind_next = RK_DOUBLE;
        end else
        begin
            kind_next = RK_COMPLEX;
        end
        b33 = NB_W'(s2_b_reg);
    end

    // Datapath registers of all three stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_xx_reg <= 32'(cx) * 32'(cx);
            s1_bx_reg <= 32'(cb) * 32'(cx);
            s1_bb_reg <= 32'(cb) * 32'(cb);
            s1_ac_reg <= 32'(ca) * 32'(cc);
            s1_a_reg  <= ca;
            s1_b_reg  <= cb;
            s1_c_reg  <= cc;

            s2_axx_reg <= 48'(s1_a_reg) * 48'(s1_xx_reg);
            s2_bx_reg  <= s1_bx_reg;
            s2_c_reg   <= s1_c_reg;
            s2_a_reg   <= s1_a_reg;
            s2_b_reg   <= s1_b_reg;
            s2_d_reg   <= d_next;
            s2_ext_reg <= ext_next;

            s3_val_reg  <= vclip.v;
            s3_sat_reg  <= vclip.sat;
            s3_kind_reg <= kind_next;
            s3_dmag_reg <= SQ_IN_W'(s2_d_reg < 0 ? -s2_d_reg : s2_d_reg);
            s3_nb_reg   <= -(b33 <<< 16);
            s3_a_reg    <= s2_a_reg;
            s3_ext_reg  <= s2_ext_reg;
        end
    end

    assign out_valid = v3_reg;
    assign val       = s3_val_reg;
    assign val_sat   = s3_sat_reg;
    assign kind      = s3_kind_reg;
    assign d_mag     = s3_dmag_reg;
    assign nb        = s3_nb_reg;
    assign a         = s3_a_reg;
    assign ext_num   = s3_ext_reg;

endmodule

// ===== rtl/core/qes_sqrt.sv =====
// Pipelined digit-by-digit square root: floor(sqrt(m) * 2^16), one root bit a stage.
// Depends on qes_pkg.
`timescale 1ns / 1ps

module qes_sqrt
    import qes_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [SQ_IN_W-1:0]   m,
    output logic [SQ_ROOT_W-1:0] root
);

    logic [SQ_REM_W-1:0]  rem_reg  [SQ_STEPS];
    logic [SQ_ROOT_W-1:0] root_reg [SQ_STEPS];
    logic [SQ_IN_W-1:0]   m_reg    [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        localparam int I = SQ_STEPS - 1 - k;

        logic [SQ_REM_W-1:0]  rem_in;
        logic [SQ_ROOT_W-1:0] root_in;
        logic [SQ_IN_W-1:0]   m_in;
        logic [1:0]           pair;
        logic [SQ_REM_W+1:0]  rem_sh, trial;
        logic                 ge;
        logic [SQ_REM_W-1:0]  rem_next;
        logic [SQ_ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign m_in    = m;
        end else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign m_in    = m_reg[k-1];
        end

        // Integer digits come from the radicand, fraction digits are zero.
        if (I >= SQ_FRAC)
        begin : g_pair
            assign pair = m_in[2*(I-SQ_FRAC)+1 -: 2];
        end else
        begin : g_zero
            assign pair = 2'b00;
        end

        // Try the next root bit against the partial remainder.
        always_comb
        begin
            rem_sh    = {rem_in, pair};
            trial     = (SQ_REM_W+2)'({root_in, 2'b01});
            ge        = (rem_sh >= trial);
            rem_next  = SQ_REM_W'(ge ? rem_sh - trial : rem_sh);
            root_next = {root_in[SQ_ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                m_reg[k]    <= m_in;
            end
        end
    end

    assign root = root_reg[SQ_STEPS-1];

endmodule

// ===== rtl/core/qes_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit a stage.
// Depends on qes_pkg.
`timescale 1ns / 1ps

module qes_div
    import qes_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [DIV_N-1:0] num,
    input  logic [DIV_M-1:0] den,
    output logic [DIV_N-1:0] quo
);

    logic [DIV_M-1:0] rem_reg  [DIV_N];
    logic [DIV_N-1:0] work_reg [DIV_N];
    logic [DIV_M-1:0] den_reg  [DIV_N];

    for (genvar k = 0; k < DIV_N; k++)
    begin : g_step
        logic [DIV_M-1:0] rem_in, den_in, rem_next;
        logic [DIV_N-1:0] work_in, work_next;
        logic [DIV_M:0]   sh;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign work_in = num;
            assign den_in  = den;
        end else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign work_in = work_reg[k-1];
            assign den_in  = den_reg[k-1];
        end

        // Dividend bits leave at the top, quotient bits enter at the bottom.
        always_comb
        begin
            sh        = {rem_in, work_in[DIV_N-1]};
            ge        = (sh >= {1'b0, den_in});
            rem_next  = DIV_M'(ge ? sh - {1'b0, den_in} : sh);
            work_next = {work_in[DIV_N-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                work_reg[k] <= work_next;
                den_reg[k]  <= den_in;
            end
        end
    end

    assign quo = work_reg[DIV_N-1];

endmodule

// ===== rtl/core/quadratic_equation_solver.sv =====
// Top level of the quadratic equation solver: front end, square root,
// dividers and output buffering. Depends on qes_pkg and all qes_* modules.
`timescale 1ns / 1ps
//
// Usage:
// A coefficient word (a, b, c and the point x, signed Q8.8) enters on the coef
// channel when coef_valid is high and coef_stall is low. One result word leaves
// on the result channel per coefficient word, in order, and is taken when
// result_valid is high and result_stall is low.
// From acceptance to result_valid a word passes 3 front end stages,
// 33 square root stages (one root bit each), one operand stage, 40 divider
// stages (one quotient bit each), one result stage and the output register.
// Throughput is one word per cycle while the pipeline does not hold; every
// stage is a register and the dividers and the square root are fully pipelined.
// When the receiver stalls, the output register holds its word and one more
// word drops into a skid register; only then does coef_stall rise and the
// whole pipeline hold, so nothing is lost or repeated.
// Reset clears all valid bits, the output register and the skid register.
//
module quadratic_equation_solver
    import qes_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    coef_valid,
    output logic    coef_stall,
    input  coef_t   coef,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef struct packed {
        logic signed [OUT_W-1:0] val;
        logic                    val_sat;
        logic [1:0]              kind;
        logic signed [NB_W-1:0]  nb;
        logic signed [IN_W-1:0]  a;
        logic signed [EXT_W-1:0] ext_num;
    } side_a_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] val;
        logic                    val_sat;
        logic [1:0]              kind;
        logic                    a_neg;
        logic                    q1_neg;
        logic                    q2_neg;
        logic                    qe_neg;
    } side_b_t;

    logic en;
    logic skid_valid_reg, out_valid_reg;
    result_t skid_reg, out_reg;

    // Front end outputs.
    logic    fr_valid;
    side_a_t fr_side;
    logic [SQ_IN_W-1:0] fr_dmag;

    // Square root and its side line.
    logic [SQ_ROOT_W-1:0] root;
    logic    sa_valid;
    side_a_t sa_out;

    // Operand stage.
    logic             s4_valid_reg;
    side_b_t          s4_side_reg, s4_side_next;
    logic [DIV_N-1:0] s4_mag1_reg, s4_mag2_reg, s4_mage_reg;
    logic [DIV_N-1:0] mag1_next, mag2_next, mage_next;
    logic [DIV_M-1:0] s4_denr_reg, s4_dene_reg, denr_next, dene_next;

    // Dividers and their side line.
    logic [DIV_N-1:0] q1, q2, qe;
    logic    sb_valid;
    side_b_t sb_out;

    // Result stage.
    logic    s5_valid_reg;
    result_t s5_reg, s5_next;

    assign en         = !skid_valid_reg;
    assign coef_stall = skid_valid_reg;

    qes_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (coef_valid && !coef_stall),
        .coef      (coef),
        .out_valid (fr_valid),
        .val       (fr_side.val),
        .val_sat   (fr_side.val_sat),
        .kind      (fr_side.kind),
        .d_mag     (fr_dmag),
        .nb        (fr_side.nb),
        .a         (fr_side.a),
        .ext_num   (fr_side.ext_num)
    );

    qes_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .m    (fr_dmag),
        .root (root)
    );

    qes_delay #(
        .W ($bits(side_a_t)),
        .L (SQ_STEPS)
    ) u_side_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_data   (fr_side),
        .out_valid (sa_valid),
        .out_data  (sa_out)
    );

    // Operand stage: signed numerators and divisors become magnitudes and signs.
    always_comb
    begin
        logic signed [35:0]      nb36, s36, n1, n2;
        logic signed [17:0]      a18, ta;
        logic signed [EXT_W-1:0] e40;
        nb36 = 36'(sa_out.nb);
        s36  = $signed(36'(root));
        unique case (sa_out.kind)
            RK_TWO:
            begin
                n1 = nb36 - s36;
                n2 = nb36 + s36;
            end
            RK_DOUBLE:
            begin
                n1 = nb36;
                n2 = '0;
            end
            RK_COMPLEX:
            begin
                n1 = nb36;
                n2 = s36;
            end
            RK_NONE:
            begin
                n1 = '0;
                n2 = '0;
            end
        endcase
        a18 = 18'(sa_out.a);
        ta  = a18 <<< 1;
        e40 = sa_out.ext_num;
        mag1_next = DIV_N'(n1 < 0 ? -n1 : n1);
        mag2_next = DIV_N'(n2 < 0 ? -n2 : n2);
        mage_next = DIV_N'(e40 < 0 ? -e40 : e40);
        denr_next = DIV_M'(ta < 0 ? -ta : ta);
        dene_next = DIV_M'(a18 < 0 ? -a18 : a18);
        s4_side_next.val     = sa_out.val;
        s4_side_next.val_sat = sa_out.val_sat;
        s4_side_next.kind    = sa_out.kind;
        s4_side_next.a_neg   = sa_out.a[IN_W-1];
        s4_side_next.q1_neg  = n1[35] ^ sa_out.a[IN_W-1];
        s4_side_next.q2_neg  = n2[35] ^ sa_out.a[IN_W-1];
        s4_side_next.qe_neg  = e40[EXT_W-1] ^ sa_out.a[IN_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end else if (en)
        begin
            s4_valid_reg <= sa_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s4_side_next;
            s4_mag1_reg <= mag1_next;
            s4_mag2_reg <= mag2_next;
            s4_mage_reg <= mage_next;
            s4_denr_reg <= denr_next;
            s4_dene_reg <= dene_next;
        end
    end

    qes_div u_div_first (
        .clk (clk),
        .en  (en),
        .num (s4_mag1_reg),
        .den (s4_denr_reg),
        .quo (q1)
    );

    qes_div u_div_second (
        .clk (clk),
        .en  (en),
        .num (s4_mag2_reg),
        .den (s4_denr_reg),
        .quo (q2)
    );

    qes_div u_div_ext (
        .clk (clk),
        .en  (en),
        .num (s4_mage_reg),
        .den (s4_dene_reg),
        .quo (qe)
    );

    qes_delay #(
        .W ($bits(side_b_t)),
        .L (DIV_N)
    ) u_side_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .in_data   (s4_side_reg),
        .out_valid (sb_valid),
        .out_data  (sb_out)
    );

    // Result stage: restore signs, saturate and pick the words for the root kind.
    always_comb
    begin
        logic signed [63:0] v1, v2, ve;
        clip_t c1, c2, ce;
        v1 = sb_out.q1_neg ? -$signed(64'(q1)) : $signed(64'(q1));
        v2 = sb_out.q2_neg ? -$signed(64'(q2)) : $signed(64'(q2));
        ve = sb_out.qe_neg ? -$signed(64'(qe)) : $signed(64'(qe));
        c1 = clip_out(v1);
        c2 = clip_out(v2);
        ce = clip_out(ve);
        s5_next.value_at_point = sb_out.val;
        s5_next.root_kind      = sb_out.kind;
        unique case (sb_out.kind)
            RK_NONE:
            begin
                s5_next.root_first    = '0;
                s5_next.root_second   = '0;
                s5_next.extreme_kind  = EK_NONE;
                s5_next.extreme_value = '0;
                s5_next.saturated     = sb_out.val_sat;
            end
            RK_DOUBLE:
            begin
                s5_next.root_first    = c1.v;
                s5_next.root_second   = '0;
                s5_next.extreme_kind  = sb_out.a_neg ? EK_MAX : EK_MIN;
                s5_next.extreme_value = ce.v;
                s5_next.saturated     = sb_out.val_sat | c1.sat | ce.sat;
            end
            RK_TWO, RK_COMPLEX:
            begin
                s5_next.root_first    = c1.v;
                s5_next.root_second   = c2.v;
                s5_next.extreme_kind  = sb_out.a_neg ? EK_MAX : EK_MIN;
                s5_next.extreme_value = ce.v;
                s5_next.saturated     = sb_out.val_sat | c1.sat | c2.sat | ce.sat;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end else if (en)
        begin
            s5_valid_reg <= sb_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg <= s5_next;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end else if (!out_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else
            begin
                out_reg       <= s5_reg;
                out_valid_reg <= s5_valid_reg;
            end
        end else if (s5_valid_reg && en)
        begin
            skid_reg       <= s5_reg;
            skid_valid_reg <= 1'b1;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A word waits in the skid register only behind a word in the output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without an output word");

    // Without a quadratic term the root and extremum words are all clear.
    a_none_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.root_kind == RK_NONE) |->
        (result.extreme_kind == EK_NONE && result.root_first == '0 &&
         result.root_second == '0 && result.extreme_value == '0))
        else $error("non-quadratic result carries root data");

    // A double root has a zero second word and a valid extremum kind.
    a_double_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.root_kind == RK_DOUBLE) |->
        (result.root_second == '0 &&
         (result.extreme_kind == EK_MIN || result.extreme_kind == EK_MAX)))
        else $error("double root result malformed");

    // The skid word stays while stalled; the pipeline holds only while the skid is full.
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && result_stall) |=> skid_valid_reg)
        else $error("skid word dropped while stalled");

endmodule

// ===== tb/tb_quadratic_equation_solver.sv =====
// Testbench of the quadratic equation solver: random and directed coefficient words,
// predicted results checked in order. Depends on qes_pkg and the solver RTL.
`timescale 1ns / 1ps

import qes_pkg::*;

// Holds the predicted result words and checks each arriving word against them.
class solution_board;
    result_t pending[$];
    int      errors;

    function new();
        errors = 0;
    endfunction

    // Square root of m, times 2^16, truncated, one result bit per step.
    function automatic longint root_q16(longint unsigned m);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned pair;
        longint unsigned trial;
        rem  = 0;
        root = 0;
        for (int i = 32; i >= 0; i--)
        begin
            pair  = (i >= 16) ? ((m >> (2 * (i - 16))) & 3) : 0;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return longint'(root);
    endfunction

    function automatic logic signed [31:0] limit(longint v, ref logic sat);
        longint hi;
        longint lo;
        hi = 64'sd2147483647;
        lo = -hi - 1;
        if (v > hi)
        begin
            sat = 1'b1;
            return hi[31:0];
        end
        if (v < lo)
        begin
            sat = 1'b1;
            return lo[31:0];
        end
        return v[31:0];
    endfunction

    // Predict the result of one accepted coefficient word.
    function void note_coef(coef_t w);
        result_t r;
        longint  a;
        longint  b;
        longint  c;
        longint  x;
        longint  d;
        longint  s;
        longint  nb;
        logic    sat;
        a   = longint'(w.coef_a);
        b   = longint'(w.coef_b);
        c   = longint'(w.coef_c);
        x   = longint'(w.point_x);
        sat = 1'b0;
        r   = '0;
        r.value_at_point = limit((a * x * x + 256 * b * x + 65536 * c) / 256, sat);
        r.root_kind      = RK_NONE;
        r.extreme_kind   = EK_NONE;
        if (a != 0)
        begin
            d  = b * b - 4 * a * c;
            nb = -65536 * b;
            if (d > 0)
            begin
                s = root_q16(d);
                r.root_kind   = RK_TWO;
                r.root_first  = limit((nb - s) / (2 * a), sat);
                r.root_second = limit((nb + s) / (2 * a), sat);
            end
            else if (d == 0)
            begin
                r.root_kind  = RK_DOUBLE;
                r.root_first = limit(nb / (2 * a), sat);
            end
            else
            begin
                s = root_q16(-d);
                r.root_kind   = RK_COMPLEX;
                r.root_first  = limit(nb / (2 * a), sat);
                r.root_second = limit(s / (2 * a), sat);
            end
            r.extreme_kind  = (a > 0) ? EK_MIN : EK_MAX;
            r.extreme_value = limit((256 * a * c - 64 * b * b) / a, sat);
        end
        r.saturated = sat;
        pending.push_back(r);
    endfunction

    // Compare one arriving result word with the oldest prediction.
    function void check_result(result_t got);
        result_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.value_at_point !== e.value_at_point)
        begin
            $display("%0t: value_at_point expected %0d actual %0d", $time,
                     e.value_at_point, got.value_at_point);
            errors++;
        end
        if (got.root_kind !== e.root_kind)
        begin
            $display("%0t: root_kind expected %0d actual %0d", $time,
                     e.root_kind, got.root_kind);
            errors++;
        end
        if (got.root_first !== e.root_first)
        begin
            $display("%0t: root_first expected %0d actual %0d", $time,
                     e.root_first, got.root_first);
            errors++;
        end
        if (got.root_second !== e.root_second)
        begin
            $display("%0t: root_second expected %0d actual %0d", $time,
                     e.root_second, got.root_second);
            errors++;
        end
        if (got.extreme_kind !== e.extreme_kind)
        begin
            $display("%0t: extreme_kind expected %0d actual %0d", $time,
                     e.extreme_kind, got.extreme_kind);
            errors++;
        end
        if (got.extreme_value !== e.extreme_value)
        begin
            $display("%0t: extreme_value expected %0d actual %0d", $time,
                     e.extreme_value, got.extreme_value);
            errors++;
        end
        if (got.saturated !== e.saturated)
        begin
            $display("%0t: saturated expected %0b actual %0b", $time,
                     e.saturated, got.saturated);
            errors++;
        end
    endfunction
endclass

module tb_quadratic_equation_solver;
    logic    clk;
    logic    rst_n;
    logic    coef_valid;
    logic    coef_stall;
    coef_t   coef;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    solution_board board;

    quadratic_equation_solver uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .coef_valid   (coef_valid),
        .coef_stall   (coef_stall),
        .coef         (coef),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock with a 12 ns period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Draw a coefficient, mostly full-range random values with small values, zero and the extremes mixed in.
    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3, 4: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom());
        endcase
    endfunction

    // Offer one word after a random gap and hold it until it is taken.
    // Valid stays high after the word is taken; the next call replaces or
    // drops it, and idle_input drops it.
    task automatic send_word(coef_t w);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            coef_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        coef_valid <= 1'b1;
        coef       <= w;
        @(posedge clk);
        while (coef_stall)
            @(posedge clk);
        board.note_coef(w);
    endtask

    // Stop offering words.
    task automatic idle_input();
        coef_valid <= 1'b0;
    endtask

    task automatic send_abcx(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] x);
        coef_t w;
        w.coef_a  = a;
        w.coef_b  = b;
        w.coef_c  = c;
        w.point_x = x;
        send_word(w);
    endtask

    // Check every result word that is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                board.check_result(result);
        end
    end

    // Result side: a random wait before each word, and one long hold-off.
    initial
    begin
        int n;
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        result_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(0, 4);
            if (!held && taken == 250)
            begin
                held = 1'b1;
                n    = 400;
            end
            if (n != 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            taken++;
        end
    end

    // Stimulus.
    initial
    begin
        board        = new();
        rst_n        = 1'b0;
        coef_valid   = 1'b0;
        coef         = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: not quadratic, two real, double, complex, extremes, saturation.
        send_abcx(16'h0000, 16'h0100, 16'h0200, 16'h0300);
        send_abcx(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_abcx(16'h0100, 16'hfd00, 16'h0200, 16'h0100);
        send_abcx(16'h0100, 16'h0200, 16'h0100, 16'hff00);
        send_abcx(16'h0100, 16'h0000, 16'h0100, 16'h0000);
        send_abcx(16'hff00, 16'h0000, 16'hff00, 16'h0080);
        send_abcx(16'hff00, 16'h0300, 16'h0100, 16'h0200);
        send_abcx(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_abcx(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_abcx(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_abcx(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_abcx(16'h0001, 16'h7fff, 16'h0000, 16'h0001);
        send_abcx(16'hffff, 16'h8000, 16'h7fff, 16'hffff);
        send_abcx(16'h0001, 16'h0000, 16'h8000, 16'h0000);
        send_abcx(16'h0001, 16'h0002, 16'h0001, 16'h5555);
        send_abcx(16'hffff, 16'hfffe, 16'hffff, 16'haaaa);
        send_abcx(16'h0000, 16'h7fff, 16'h7fff, 16'h7fff);

        // Let every prediction drain before the random part.
        idle_input();
        do
            @(posedge clk);
        while (board.pending.size() != 0);

        for (int i = 0; i < 750; i++)
        begin
            if (i == 500)
            begin
                idle_input();
                do
                    @(posedge clk);
                while (board.pending.size() != 0);
            end
            send_abcx(pick_coef(), pick_coef(), pick_coef(), pick_coef());
        end

        idle_input();
        do
            @(posedge clk);
        while (board.pending.size() != 0);
        repeat (100) @(posedge clk);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
